// ----- sv/dns_reply_ipv4_extractor_unit_defines.svh -----
// ----------------------------------------------------------------------------
// DNS reply IPv4 extractor - assertion macros
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DNS_REPLY_IPV4_EXTRACTOR_UNIT_DEFINES_SVH
`define DNS_REPLY_IPV4_EXTRACTOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent
`define DRIE_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed: same-cycle implication");
// Consequent must hold in the cycle after the antecedent
`define DRIE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed: next-cycle implication");
`else
`define DRIE_ASSERT_SAME(label, ante, cons)
`define DRIE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- sv/drie_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS reply IPv4 extractor - shared package
// Parser phase codes, result status codes, message layout constants and the
// result record passed from the parser to the output stage.
// ----------------------------------------------------------------------------
package drie_pkg;

	// Parser phases
	localparam logic [3:0] PH_HEADER  = 4'd0;
	localparam logic [3:0] PH_NAME    = 4'd1;
	localparam logic [3:0] PH_LABEL   = 4'd2;
	localparam logic [3:0] PH_POINTER = 4'd3;
	localparam logic [3:0] PH_QFIXED  = 4'd4;
	localparam logic [3:0] PH_AFIXED  = 4'd5;
	localparam logic [3:0] PH_RDATA   = 4'd6;
	localparam logic [3:0] PH_ADDR    = 4'd7;
	localparam logic [3:0] PH_DONE    = 4'd8;

	// Result status codes
	localparam logic [1:0] ST_FOUND        = 2'd0;
	localparam logic [1:0] ST_NOT_RESPONSE = 2'd1;
	localparam logic [1:0] ST_BAD_QUESTION = 2'd2;
	localparam logic [1:0] ST_NO_ANSWER    = 2'd3;

	// Byte positions and section lengths
	localparam logic [3:0] OFF_FLAGS     = 4'd2;
	localparam logic [3:0] OFF_QDCOUNT_H = 4'd4;
	localparam logic [3:0] OFF_QDCOUNT_L = 4'd5;
	localparam logic [3:0] OFF_ANCOUNT_H = 4'd6;
	localparam logic [3:0] OFF_ANCOUNT_L = 4'd7;
	localparam logic [3:0] OFF_RDLEN_H   = 4'd8;
	localparam logic [3:0] OFF_RDLEN_L   = 4'd9;
	localparam logic [3:0] TYPE_BYTES    = 4'd2;
	localparam logic [3:0] HEADER_BYTES  = 4'd12;
	localparam logic [3:0] QFIXED_BYTES  = 4'd4;
	localparam logic [3:0] AFIXED_BYTES  = 4'd10;
	localparam logic [3:0] ADDR_BYTES    = 4'd4;

	localparam logic [15:0] TYPE_A    = 16'd1;
	localparam logic [15:0] A_RDLEN   = 16'd4;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] addr;
	} result_t;

endpackage

// ----- sv/drie_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS reply IPv4 extractor - byte parser
// Walks header, question and answer sections one byte per transaction and
// raises a result when the message outcome is decided.
// ----------------------------------------------------------------------------
module drie_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	output logic              res_valid,
	output drie_pkg::result_t res,
	output logic [3:0]        phase
);
	import drie_pkg::*;

	logic [3:0]  ph_q, ph_d;
	logic [3:0]  off_q, off_d, off_inc;
	logic [15:0] qleft_q, qleft_d;
	logic [15:0] aleft_q, aleft_d;
	logic [15:0] skip_q, skip_d;
	logic [15:0] rtype_q, rtype_d;
	logic [15:0] rdlen_q, rdlen_d;
	logic [31:0] accum_q, accum_d;
	logic        emit;
	logic [1:0]  emit_status;
	logic [31:0] emit_addr;

	always_comb begin
		ph_d        = ph_q;
		off_d       = off_q;
		qleft_d     = qleft_q;
		aleft_d     = aleft_q;
		skip_d      = skip_q;
		rtype_d     = rtype_q;
		rdlen_d     = rdlen_q;
		accum_d     = accum_q;
		emit        = 1'b0;
		emit_status = ST_NO_ANSWER;
		emit_addr   = '0;
		off_inc     = off_q + 4'd1;
		case (ph_q)
			PH_HEADER: begin
				if (off_q == OFF_FLAGS && !data_byte[7]) begin
					emit        = 1'b1;
					emit_status = ST_NOT_RESPONSE;
				end else begin
					if (off_q == OFF_QDCOUNT_H || off_q == OFF_QDCOUNT_L)
						qleft_d = {qleft_q[7:0], data_byte};
					if (off_q == OFF_ANCOUNT_H || off_q == OFF_ANCOUNT_L)
						aleft_d = {aleft_q[7:0], data_byte};
					off_d = off_inc;
					if (off_inc == HEADER_BYTES) begin
						off_d = '0;
						if (qleft_d == '0 && aleft_d == '0)
							emit = 1'b1;
						else
							ph_d = PH_NAME;
					end
				end
			end
			PH_NAME: begin
				if (data_byte == 8'h00) begin
					off_d   = '0;
					rtype_d = '0;
					ph_d    = (qleft_q != '0) ? PH_QFIXED : PH_AFIXED;
				end else if (data_byte[7]) begin
					ph_d = PH_POINTER;
				end else begin
					skip_d = {8'h00, data_byte};
					ph_d   = PH_LABEL;
				end
			end
			PH_LABEL: begin
				skip_d = skip_q - 16'd1;
				if (skip_d == '0)
					ph_d = PH_NAME;
			end
			PH_POINTER: begin
				// second pointer byte ends the name
				off_d   = '0;
				rtype_d = '0;
				ph_d    = (qleft_q != '0) ? PH_QFIXED : PH_AFIXED;
			end
			PH_QFIXED: begin
				if (off_q < TYPE_BYTES)
					rtype_d = {rtype_q[7:0], data_byte};
				off_d = off_inc;
				if (off_inc == TYPE_BYTES && rtype_d != TYPE_A) begin
					emit        = 1'b1;
					emit_status = ST_BAD_QUESTION;
				end else if (off_inc == QFIXED_BYTES) begin
					off_d   = '0;
					qleft_d = qleft_q - 16'd1;
					if (qleft_d == '0 && aleft_q == '0)
						emit = 1'b1;
					else
						ph_d = PH_NAME;
				end
			end
			PH_AFIXED: begin
				if (off_q < TYPE_BYTES)
					rtype_d = {rtype_q[7:0], data_byte};
				if (off_q == OFF_RDLEN_H || off_q == OFF_RDLEN_L)
					rdlen_d = {rdlen_q[7:0], data_byte};
				off_d = off_inc;
				if (off_inc == AFIXED_BYTES) begin
					off_d  = '0;
					skip_d = rdlen_d;
					if (rtype_d == TYPE_A && rdlen_d == A_RDLEN) begin
						accum_d = '0;
						ph_d    = PH_ADDR;
					end else if (rdlen_d == '0) begin
						aleft_d = aleft_q - 16'd1;
						if (aleft_d == '0)
							emit = 1'b1;
						else
							ph_d = PH_NAME;
					end else begin
						ph_d = PH_RDATA;
					end
				end else if (off_inc == OFF_RDLEN_H) begin
					rdlen_d = '0;
				end
			end
			PH_RDATA: begin
				skip_d = skip_q - 16'd1;
				if (skip_d == '0) begin
					aleft_d = aleft_q - 16'd1;
					if (aleft_d == '0)
						emit = 1'b1;
					else
						ph_d = PH_NAME;
				end
			end
			PH_ADDR: begin
				accum_d = {accum_q[23:0], data_byte};
				off_d   = off_inc;
				if (off_inc == ADDR_BYTES) begin
					emit        = 1'b1;
					emit_status = ST_FOUND;
					emit_addr   = accum_d;
				end
			end
			default: begin
				// decided: drop bytes until the last one
			end
		endcase
		if (emit)
			ph_d = PH_DONE;
	end

	// A truncated message reports no answer on its last byte
	assign res_valid  = emit || (last_byte && ph_q != PH_DONE);
	assign res.status = emit_status;
	assign res.addr   = emit_addr;
	assign phase      = ph_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= PH_HEADER;
			off_q   <= '0;
			qleft_q <= '0;
			aleft_q <= '0;
			skip_q  <= '0;
			rtype_q <= '0;
			rdlen_q <= '0;
			accum_q <= '0;
		end else if (take) begin
			if (last_byte) begin
				ph_q    <= PH_HEADER;
				off_q   <= '0;
				qleft_q <= '0;
				aleft_q <= '0;
				skip_q  <= '0;
				rtype_q <= '0;
				rdlen_q <= '0;
				accum_q <= '0;
			end else begin
				ph_q    <= ph_d;
				off_q   <= off_d;
				qleft_q <= qleft_d;
				aleft_q <= aleft_d;
				skip_q  <= skip_d;
				rtype_q <= rtype_d;
				rdlen_q <= rdlen_d;
				accum_q <= accum_d;
			end
		end
	end

endmodule

// ----- sv/drie_out_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS reply IPv4 extractor - result register
// Holds one result transaction until the downstream side takes it.
// ----------------------------------------------------------------------------
module drie_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  drie_pkg::result_t res_in,
	input  logic              stall,
	output logic              valid,
	output logic              full_stalled,
	output drie_pkg::result_t res_out
);
	import drie_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign valid        = valid_q;
	assign res_out      = res_q;
	assign full_stalled = valid_q && stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	// Load is only raised when the register is empty or being taken
	always_ff @(posedge clk) begin
		if (load)
			res_q <= res_in;
	end

endmodule

// ----- sv/dns_reply_ipv4_extractor_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS reply IPv4 extractor - top level
// Scans a DNS message byte by byte and reports the first A record address,
// or why none was found, once per message.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  --------+----------------------------+------------------------------
//  in      | in_valid / in_stall        | data_byte, last_byte
//  out     | out_valid / out_stall      | status, ipv4_address
//
// One byte is taken per cycle while in_stall is low; the parser state updates in that cycle.
// A result appears on out_valid the cycle after the byte that decides it.
// in_stall rises only while a result waits in the output register and
// out_stall is high. Reset returns the parser to the header phase and
// empties the output register. After the last byte the parser is ready
// for a new message on the next cycle.
// ----------------------------------------------------------------------------
`include "dns_reply_ipv4_extractor_unit_defines.svh"

module dns_reply_ipv4_extractor_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] ipv4_address
);
	import drie_pkg::*;

	logic       in_fire;
	logic       res_valid;
	result_t    res;
	result_t    res_out;
	logic [3:0] phase;
	logic       full_stalled;

	assign in_stall = full_stalled;
	assign in_fire  = in_valid && !in_stall;

	drie_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (in_fire),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.res_valid (res_valid),
		.res       (res),
		.phase     (phase)
	);

	drie_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (in_fire && res_valid),
		.res_in       (res),
		.stall        (out_stall),
		.valid        (out_valid),
		.full_stalled (full_stalled),
		.res_out      (res_out)
	);

	assign status       = res_out.status;
	assign ipv4_address = res_out.addr;

	`DRIE_ASSERT_SAME(a_stall_only_when_full, in_stall, out_valid)
	`DRIE_ASSERT_SAME(a_addr_zero_unless_found, out_valid && status != ST_FOUND, ipv4_address == '0)
	`DRIE_ASSERT_NEXT(a_last_restarts_header, in_fire && last_byte, phase == PH_HEADER)
	`DRIE_ASSERT_NEXT(a_result_after_last, in_fire && last_byte && phase != PH_DONE, out_valid)

endmodule

// ----- tb/sv/dns_reply_ipv4_extractor_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS reply IPv4 extractor - testbench
// Feeds directed and random DNS messages one byte per transaction. Random
// messages are mostly well-formed replies with random names, records and
// counts, plus cut, corrupted, query and noise messages. A byte-level parser
// model predicts the single reply of each message, and every reply is checked
// field by field. Both channels idle at random, with one long output hold-off
// and one pause until the block has drained.
// ----------------------------------------------------------------------------
module dns_reply_ipv4_extractor_unit_tb;
	import drie_pkg::*;

	localparam int NUM_BYTES   = 900;
	localparam int MIN_MSGS    = 40;
	localparam int IDLE_PCT    = 19;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_LIMIT = 5000;
	localparam int TAIL_CYCLES = 10;

	typedef enum int {MSG_REPLY, MSG_CUT, MSG_NOISE, MSG_QUERY} msg_kind_t;

	typedef struct {
		logic [7:0] data;
		logic       last;
		bit         pinned;
		result_t    want;
	} script_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [31:0] ipv4_address;

	// parser model state
	logic [3:0]  dns_phase;
	logic [15:0] dns_offset;
	logic [15:0] dns_qleft;
	logic [15:0] dns_aleft;
	logic [15:0] dns_skip;
	logic [15:0] dns_rtype;
	logic [15:0] dns_rdlen;
	logic [31:0] dns_addr;
	bit          dns_decided;

	result_t    expected_replies[$];
	logic [7:0] msg_bytes[$];
	int         err_count = 0;
	int         bytes_sent = 0;
	bit         steady = 1'b0;
	bit         hold_req = 1'b0;
	bit         holding = 1'b0;

	// short directed messages: not a response, empty header, truncated, lone byte
	script_row_t script[19] = '{
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b1, '{ST_NOT_RESPONSE, 32'h0}},
		'{8'h7F, 1'b1, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h80, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b1, 1'b1, '{ST_NO_ANSWER, 32'h0}},
		'{8'h12, 1'b0, 1'b0, '0},
		'{8'h34, 1'b1, 1'b1, '{ST_NO_ANSWER, 32'h0}},
		'{8'h80, 1'b1, 1'b1, '{ST_NO_ANSWER, 32'h0}}
	};

	dns_reply_ipv4_extractor_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.ipv4_address (ipv4_address)
	);

	always #10 clk = ~clk;

	initial begin
		#2_000_000;
		$display("dns_reply_ipv4_extractor_unit_tb: done, errors");
		$finish;
	end

	task automatic flag_mismatch(input string what);
		err_count++;
		$display("MISMATCH at %0t ns: %s", $time, what);
	endtask

	function automatic void parser_clear();
		dns_phase = PH_HEADER;
		dns_offset = '0;
		dns_qleft = '0;
		dns_aleft = '0;
		dns_skip = '0;
		dns_rtype = '0;
		dns_rdlen = '0;
		dns_addr = '0;
		dns_decided = 1'b0;
	endfunction

	function automatic void parser_name_end();
		dns_offset = '0;
		dns_rtype = '0;
		dns_phase = (dns_qleft != 0) ? PH_QFIXED : PH_AFIXED;
	endfunction

	function automatic bit parser_next_answer();
		dns_aleft = dns_aleft - 16'd1;
		if (dns_aleft == 0)
			return 1'b1;
		dns_phase = PH_NAME;
		return 1'b0;
	endfunction

	// Advance the model by one byte; return 1 when the byte yields the reply.
	function automatic bit parse_byte(input logic [7:0] b, input logic last,
			output result_t rep);
		bit hit;
		hit = 1'b0;
		rep.status = ST_NO_ANSWER;
		rep.addr = '0;
		if (!dns_decided) begin
			case (dns_phase)
			PH_HEADER: begin
				if (dns_offset == OFF_FLAGS && !b[7]) begin
					hit = 1'b1;
					rep.status = ST_NOT_RESPONSE;
				end else begin
					if (dns_offset == OFF_QDCOUNT_H || dns_offset == OFF_QDCOUNT_L)
						dns_qleft = {dns_qleft[7:0], b};
					if (dns_offset == OFF_ANCOUNT_H || dns_offset == OFF_ANCOUNT_L)
						dns_aleft = {dns_aleft[7:0], b};
					dns_offset = dns_offset + 16'd1;
					if (dns_offset == HEADER_BYTES) begin
						dns_offset = '0;
						if (dns_qleft == 0 && dns_aleft == 0)
							hit = 1'b1;
						else
							dns_phase = PH_NAME;
					end
				end
			end
			PH_NAME: begin
				if (b == 8'h00) begin
					parser_name_end();
				end else if (b[7]) begin
					dns_phase = PH_POINTER;
				end else begin
					dns_skip = {8'h00, b};
					dns_phase = PH_LABEL;
				end
			end
			PH_LABEL: begin
				dns_skip = dns_skip - 16'd1;
				if (dns_skip == 0)
					dns_phase = PH_NAME;
			end
			PH_POINTER: parser_name_end();
			PH_QFIXED: begin
				if (dns_offset < TYPE_BYTES)
					dns_rtype = {dns_rtype[7:0], b};
				dns_offset = dns_offset + 16'd1;
				if (dns_offset == TYPE_BYTES && dns_rtype != TYPE_A) begin
					hit = 1'b1;
					rep.status = ST_BAD_QUESTION;
				end else if (dns_offset == QFIXED_BYTES) begin
					dns_offset = '0;
					dns_qleft = dns_qleft - 16'd1;
					if (dns_qleft == 0 && dns_aleft == 0)
						hit = 1'b1;
					else
						dns_phase = PH_NAME;
				end
			end
			PH_AFIXED: begin
				if (dns_offset < TYPE_BYTES)
					dns_rtype = {dns_rtype[7:0], b};
				if (dns_offset == OFF_RDLEN_H || dns_offset == OFF_RDLEN_L)
					dns_rdlen = {dns_rdlen[7:0], b};
				dns_offset = dns_offset + 16'd1;
				if (dns_offset == AFIXED_BYTES) begin
					dns_offset = '0;
					dns_skip = dns_rdlen;
					if (dns_rtype == TYPE_A && dns_rdlen == A_RDLEN) begin
						dns_addr = '0;
						dns_phase = PH_ADDR;
					end else if (dns_rdlen == 0) begin
						hit = parser_next_answer();
					end else begin
						dns_phase = PH_RDATA;
					end
				end else if (dns_offset == OFF_RDLEN_H) begin
					dns_rdlen = '0;
				end
			end
			PH_RDATA: begin
				dns_skip = dns_skip - 16'd1;
				if (dns_skip == 0)
					hit = parser_next_answer();
			end
			PH_ADDR: begin
				dns_addr = {dns_addr[23:0], b};
				dns_offset = dns_offset + 16'd1;
				if (dns_offset == ADDR_BYTES) begin
					hit = 1'b1;
					rep.status = ST_FOUND;
					rep.addr = dns_addr;
				end
			end
			default: ;
			endcase
			if (hit) begin
				dns_decided = 1'b1;
				dns_phase = PH_DONE;
			end
		end
		if (last) begin
			// a message cut short before any decision still gets its reply
			if (!dns_decided) begin
				hit = 1'b1;
				rep.status = ST_NO_ANSWER;
				rep.addr = '0;
			end
			parser_clear();
		end
		return hit;
	endfunction

	function automatic void put16(input logic [15:0] v);
		msg_bytes.push_back(v[15:8]);
		msg_bytes.push_back(v[7:0]);
	endfunction

	function automatic void put_random(input int n);
		repeat (n) msg_bytes.push_back(8'($urandom));
	endfunction

	// Labels of random content, closed by a zero byte or a compression pointer.
	function automatic void put_name();
		int labels;
		int len;
		labels = $urandom_range(0, 2);
		repeat (labels) begin
			len = ($urandom_range(99) < 3) ? $urandom_range(63, 127) : $urandom_range(1, 6);
			msg_bytes.push_back(8'(len));
			put_random(len);
		end
		if ($urandom_range(1)) begin
			msg_bytes.push_back(8'h00);
		end else begin
			msg_bytes.push_back({1'b1, 7'($urandom)});
			put_random(1);
		end
	endfunction

	function automatic void build_reply();
		logic [15:0] qd;
		logic [15:0] an;
		logic [15:0] rtype;
		logic [15:0] rdlen;
		int pick;
		msg_bytes.delete();
		qd = $urandom_range(0, 2);
		an = $urandom_range(0, 3);
		if ($urandom_range(99) < 5)
			qd = 16'($urandom);
		if ($urandom_range(99) < 5)
			an = 16'($urandom);
		put_random(2);
		msg_bytes.push_back({1'($urandom_range(99) >= 5), 7'($urandom)});
		put_random(1);
		put16(qd);
		put16(an);
		put_random(4);
		for (int i = 0; i < qd && i < 3; i++) begin
			put_name();
			put16(($urandom_range(99) < 90) ? TYPE_A : 16'($urandom));
			put_random(2);
		end
		for (int i = 0; i < an && i < 4; i++) begin
			put_name();
			pick = $urandom_range(99);
			if (pick < 60)
				rtype = TYPE_A;
			else if (pick < 80)
				rtype = 16'($urandom_range(0, 255));
			else
				rtype = 16'($urandom);
			put16(rtype);
			put_random(6);
			if (rtype == TYPE_A && $urandom_range(99) < 85)
				rdlen = A_RDLEN;
			else if ($urandom_range(99) < 4)
				rdlen = 16'($urandom_range(256, 300));
			else
				rdlen = 16'($urandom_range(0, 8));
			put16(rdlen);
			put_random(rdlen);
		end
		if ($urandom_range(99) < 30)
			put_random($urandom_range(1, 5));
	endfunction

	task automatic send_byte(input logic [7:0] d, input logic l, input bit pinned,
			input result_t want);
		result_t rep;
		bit held;
		bit hit;
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= d;
		last_byte <= l;
		do begin
			@(negedge clk);
			held = in_stall;
			@(posedge clk);
		end while (held);
		bytes_sent++;
		hit = parse_byte(d, l, rep);
		if (pinned)
			expected_replies.push_back(want);
		else if (hit)
			expected_replies.push_back(rep);
	endtask

	initial begin : reply_sink
		int hold_left;
		bit took;
		result_t got;
		result_t want;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			took = out_valid && !out_stall;
			got.status = status;
			got.addr = ipv4_address;
			@(posedge clk);
			if (took) begin
				if (expected_replies.size() == 0) begin
					flag_mismatch($sformatf("reply with none pending: status %0d addr %h",
						got.status, got.addr));
				end else begin
					want = expected_replies.pop_front();
					if (got.status !== want.status)
						flag_mismatch($sformatf("status %0d, want %0d",
							got.status, want.status));
					if (got.addr !== want.addr)
						flag_mismatch($sformatf("ipv4_address %h, want %h",
							got.addr, want.addr));
				end
			end
			if (hold_req && hold_left == 0) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			holding = (hold_left != 0);
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	initial begin : stimulus
		msg_kind_t kind;
		int pick;
		int cut;
		int msg_idx;
		int wait_cycles;
		parser_clear();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (script[i])
			send_byte(script[i].data, script[i].last, script[i].pinned, script[i].want);
		for (msg_idx = 0; bytes_sent < NUM_BYTES || msg_idx < MIN_MSGS; msg_idx++) begin
			steady = (msg_idx >= 8 && msg_idx < 14);
			if (msg_idx == 20)
				hold_req = 1'b1;
			if (msg_idx == 30) begin
				// drain: wait until every pending reply has come out
				in_valid <= 1'b0;
				@(posedge clk);
				while (expected_replies.size() != 0)
					@(posedge clk);
			end
			pick = $urandom_range(99);
			if (hold_req || holding)
				kind = MSG_QUERY;
			else if (pick < 70)
				kind = MSG_REPLY;
			else if (pick < 82)
				kind = MSG_CUT;
			else if (pick < 92)
				kind = MSG_NOISE;
			else
				kind = MSG_QUERY;
			case (kind)
			MSG_REPLY: build_reply();
			MSG_CUT: begin
				build_reply();
				cut = $urandom_range(1, msg_bytes.size());
				while (msg_bytes.size() > cut)
					void'(msg_bytes.pop_back());
				if ($urandom_range(99) < 30)
					msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = 8'($urandom);
			end
			MSG_NOISE: begin
				msg_bytes.delete();
				put_random($urandom_range(1, 24));
			end
			default: begin
				msg_bytes.delete();
				put_random(2);
				msg_bytes.push_back({1'b0, 7'($urandom)});
				put_random($urandom_range(0, 3));
			end
			endcase
			foreach (msg_bytes[i])
				send_byte(msg_bytes[i], (i == msg_bytes.size() - 1), 1'b0, '0);
		end
		in_valid <= 1'b0;
		for (wait_cycles = 0; expected_replies.size() != 0 && wait_cycles < DRAIN_LIMIT;
				wait_cycles++)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_replies.size() != 0)
			flag_mismatch($sformatf("%0d replies never arrived", expected_replies.size()));
		if (err_count == 0)
			$display("dns_reply_ipv4_extractor_unit_tb: done, clean");
		else
			$display("dns_reply_ipv4_extractor_unit_tb: done, errors");
		$finish;
	end

endmodule
